FILE: sv/fbba_pkg.sv
`default_nettype none

package fbba_pkg;

   localparam int unsigned MAX_BLOCKS_DEF = 1024;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned WORD_AW = 5;

   localparam int unsigned REQ_W    = 2;
   localparam int unsigned INDEX_W  = 10;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned COUNT_W  = 10;
   localparam int unsigned TOTAL_W  = 11;

   localparam logic [TOTAL_W-1:0] TOTAL_RESET = 11'd1024;
   localparam logic [TOTAL_W-1:0] TOTAL_CAP   = 11'd2047;
   localparam logic [COUNT_W-1:0] COUNT_SAT   = 10'h3FF;

   localparam logic [REQ_W-1:0] REQ_ALLOC   = 2'd0;
   localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_FORMAT  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

endpackage

`default_nettype wire

FILE: sv/fbba_map_ram.sv
`default_nettype none

module fbba_map_ram #(
   parameter int unsigned DEPTH = 32,
   parameter int unsigned AW    = 5
) (
   input  wire logic                         clock,
   input  wire logic                         wr_en,
   input  wire logic [AW-1:0]                wr_addr,
   input  wire logic [fbba_pkg::WORD_W-1:0]  wr_data,
   input  wire logic                         rd_en,
   input  wire logic [AW-1:0]                rd_addr,
   output logic      [fbba_pkg::WORD_W-1:0]  rd_data
);

   logic [fbba_pkg::WORD_W-1:0] mem [0:DEPTH-1];
   logic [fbba_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: sv/fbba_ffs.sv
`default_nettype none

module fbba_ffs (
   input  wire logic [fbba_pkg::WORD_W-1:0]  word,
   output logic                              found,
   output logic      [fbba_pkg::WORD_AW-1:0] pos
);

   always_comb begin
      found = 1'b0;
      pos   = '0;
      for (int i = fbba_pkg::WORD_W - 1; i >= 0; i--) begin
         if (word[i]) begin
            found = 1'b1;
            pos   = fbba_pkg::WORD_AW'(i);
         end
      end
   end

endmodule

`default_nettype wire

FILE: sv/free_block_bitmap_allocator.sv
// First-fit allocator over a free map of disk blocks 1 to limit-1, where limit is the smaller
// of csr_total_blocks and MAX_BLOCKS. The map lives in a RAM of 32-bit words, and one
// find-first-set unit inspects one word per cycle. After reset the map is swept to all used,
// one word a cycle, before the first request transfer is taken. An allocate scans the words
// up to the first free block (at most ceil(limit/32) words, and none when limit is below 2);
// a release reads and rewrites the word of its index, unless the index is out of range, a
// format rewrites every word of the map, and an unused request code goes straight to the
// response. One request is in progress at a time; the result waits in an output register, so
// a new request may be taken while the previous result is still stalled, and a finished result
// that finds that register still occupied holds the request port until the register is free.

`default_nettype none

module free_block_bitmap_allocator #(
   parameter int unsigned MAX_BLOCKS = fbba_pkg::MAX_BLOCKS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,

   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [fbba_pkg::REQ_W-1:0]      req_type,
   input  wire logic [fbba_pkg::INDEX_W-1:0]    req_block_index,

   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [fbba_pkg::INDEX_W-1:0]    rsp_granted_block,
   output logic      [fbba_pkg::STATUS_W-1:0]   rsp_status,
   output logic      [fbba_pkg::COUNT_W-1:0]    rsp_free_blocks,

   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [fbba_pkg::TOTAL_W-1:0]    csr_total_blocks
);

   localparam int unsigned NW     = (MAX_BLOCKS + fbba_pkg::WORD_W - 1) / fbba_pkg::WORD_W;
   localparam int unsigned WAW    = (NW > 1) ? $clog2(NW) : 1;
   localparam int unsigned FC_W   = $clog2(MAX_BLOCKS);
   localparam int unsigned FX_W   = (FC_W > fbba_pkg::COUNT_W) ? FC_W : fbba_pkg::COUNT_W;
   localparam int unsigned LWW    = fbba_pkg::TOTAL_W - fbba_pkg::WORD_AW;
   localparam int unsigned CMP_W  = (WAW > LWW) ? WAW : LWW;
   localparam int unsigned GB_W   = WAW + fbba_pkg::WORD_AW;
   localparam int unsigned GBX_W  = (GB_W > fbba_pkg::INDEX_W) ? GB_W : fbba_pkg::INDEX_W;
   localparam int unsigned CAP    = (MAX_BLOCKS < 2047) ? MAX_BLOCKS : 2047;
   localparam logic [WAW-1:0] LAST_WORD = WAW'(NW - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACHK,
      ST_RCHK,
      ST_FMT,
      ST_RESP
   } state_type;

   state_type                       state_ff, state_in;
   logic [WAW-1:0]                  word_ff, word_in;
   logic [FC_W-1:0]                 free_ff, free_in;
   logic [fbba_pkg::TOTAL_W-1:0]    total_ff, total_in;
   logic [fbba_pkg::INDEX_W-1:0]    idx_ff, idx_in;
   logic [fbba_pkg::INDEX_W-1:0]    res_granted_ff, res_granted_in;
   logic [fbba_pkg::STATUS_W-1:0]   res_status_ff, res_status_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [fbba_pkg::INDEX_W-1:0]    rsp_granted_ff, rsp_granted_in;
   logic [fbba_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [fbba_pkg::COUNT_W-1:0]    rsp_free_ff, rsp_free_in;

   logic                            ram_we;
   logic [WAW-1:0]                  ram_wa;
   logic [fbba_pkg::WORD_W-1:0]     ram_wd;
   logic                            ram_re;
   logic [WAW-1:0]                  ram_ra;
   logic [fbba_pkg::WORD_W-1:0]     ram_rd;

   logic [fbba_pkg::TOTAL_W-1:0]    lim;
   logic [fbba_pkg::TOTAL_W-1:0]    lim_m1;
   logic [CMP_W-1:0]                word_x;
   logic [CMP_W-1:0]                limw_x;
   logic [CMP_W-1:0]                lastw_x;
   logic [fbba_pkg::WORD_W-1:0]     thermo;
   logic [fbba_pkg::WORD_W-1:0]     word_mask;
   logic [fbba_pkg::WORD_W-1:0]     hit_word;
   logic                            ffs_found;
   logic [fbba_pkg::WORD_AW-1:0]    ffs_pos;
   logic [GBX_W-1:0]                gb_x;
   logic [FC_W-1:0]                 fmt_count;
   logic [FX_W-1:0]                 free_x;
   logic [fbba_pkg::COUNT_W-1:0]    free_sat;
   logic [GBX_W-1:0]                req_idx_x;
   logic [GBX_W-1:0]                idx_x;
   logic [fbba_pkg::WORD_AW-1:0]    bit_pos;
   logic                            req_out_of_range;

   fbba_map_ram #(
      .DEPTH (NW),
      .AW    (WAW)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   fbba_ffs u_ffs (
      .word  (hit_word),
      .found (ffs_found),
      .pos   (ffs_pos)
   );

   always_comb begin
      lim = (total_ff > fbba_pkg::TOTAL_W'(CAP)) ? fbba_pkg::TOTAL_W'(CAP) : total_ff;
   end

   assign lim_m1    = lim - 11'd1;
   assign word_x    = CMP_W'(word_ff);
   assign limw_x    = CMP_W'(lim[fbba_pkg::TOTAL_W-1:fbba_pkg::WORD_AW]);
   assign lastw_x   = CMP_W'(lim_m1[fbba_pkg::TOTAL_W-1:fbba_pkg::WORD_AW]);
   assign thermo    = (32'd1 << lim[fbba_pkg::WORD_AW-1:0]) - 32'd1;
   assign fmt_count = (lim == '0) ? '0 : FC_W'(lim_m1);

   // Bits of the current word that lie in the managed range 1 to limit-1.
   always_comb begin
      if (word_x < limw_x) begin
         word_mask = '1;
      end else if (word_x == limw_x) begin
         word_mask = thermo;
      end else begin
         word_mask = '0;
      end
      if (word_x == '0) begin
         word_mask[0] = 1'b0;
      end
   end

   assign hit_word  = ram_rd & word_mask;
   assign gb_x      = GBX_W'({word_ff, ffs_pos});
   assign req_idx_x = GBX_W'(req_block_index);
   assign idx_x     = GBX_W'(idx_ff);
   assign bit_pos   = idx_ff[fbba_pkg::WORD_AW-1:0];
   assign free_x    = FX_W'(free_ff);
   assign free_sat  = (free_x > FX_W'(fbba_pkg::COUNT_SAT)) ? fbba_pkg::COUNT_SAT
                                                            : free_x[fbba_pkg::COUNT_W-1:0];
   assign req_out_of_range = (req_block_index == '0)
                             || (fbba_pkg::TOTAL_W'(req_block_index) >= lim);

   always_comb begin
      state_in       = state_ff;
      word_in        = word_ff;
      free_in        = free_ff;
      total_in       = total_ff;
      idx_in         = idx_ff;
      res_granted_in = res_granted_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_free_in    = rsp_free_ff;
      ram_we         = 1'b0;
      ram_wa         = word_ff;
      ram_wd         = '0;
      ram_re         = 1'b0;
      ram_ra         = word_ff;

      if (csr_valid) begin
         total_in = csr_total_blocks;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            ram_wd = '0;
            if (word_ff == LAST_WORD) begin
               word_in  = '0;
               state_in = ST_IDLE;
            end else begin
               word_in = word_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               idx_in         = req_block_index;
               word_in        = '0;
               res_granted_in = '0;
               res_status_in  = fbba_pkg::ST_OK;
               case (req_type)
                  fbba_pkg::REQ_ALLOC: begin
                     if (lim <= 11'd1) begin
                        res_status_in = fbba_pkg::ST_FULL;
                        state_in      = ST_RESP;
                     end else begin
                        ram_re   = 1'b1;
                        ram_ra   = '0;
                        state_in = ST_ACHK;
                     end
                  end
                  fbba_pkg::REQ_RELEASE: begin
                     if (req_out_of_range) begin
                        res_status_in = fbba_pkg::ST_RANGE;
                        state_in      = ST_RESP;
                     end else begin
                        ram_re   = 1'b1;
                        ram_ra   = req_idx_x[fbba_pkg::WORD_AW +: WAW];
                        word_in  = req_idx_x[fbba_pkg::WORD_AW +: WAW];
                        state_in = ST_RCHK;
                     end
                  end
                  fbba_pkg::REQ_FORMAT: begin
                     state_in = ST_FMT;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_ACHK: begin
            if (ffs_found) begin
               ram_we         = 1'b1;
               ram_wd         = ram_rd & ~(32'd1 << ffs_pos);
               free_in        = free_ff - 1'b1;
               res_granted_in = gb_x[fbba_pkg::INDEX_W-1:0];
               res_status_in  = fbba_pkg::ST_OK;
               state_in       = ST_RESP;
            end else if (word_x == lastw_x) begin
               res_status_in = fbba_pkg::ST_FULL;
               state_in      = ST_RESP;
            end else begin
               ram_re  = 1'b1;
               ram_ra  = word_ff + 1'b1;
               word_in = word_ff + 1'b1;
            end
         end
         ST_RCHK: begin
            ram_we = 1'b1;
            ram_wa = idx_x[fbba_pkg::WORD_AW +: WAW];
            ram_wd = ram_rd | (32'd1 << bit_pos);
            if (!ram_rd[bit_pos]) begin
               free_in = free_ff + 1'b1;
            end
            state_in = ST_RESP;
         end
         ST_FMT: begin
            ram_we = 1'b1;
            ram_wd = word_mask;
            if (word_ff == LAST_WORD) begin
               free_in  = fmt_count;
               state_in = ST_RESP;
            end else begin
               word_in = word_ff + 1'b1;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = res_granted_ff;
               rsp_status_in  = res_status_ff;
               rsp_free_in    = free_sat;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         word_ff      <= '0;
         free_ff      <= '0;
         total_ff     <= fbba_pkg::TOTAL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         free_ff      <= free_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff         <= idx_in;
      res_granted_ff <= res_granted_in;
      res_status_ff  <= res_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_free_ff    <= rsp_free_in;
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted_block = rsp_granted_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_free_blocks   = rsp_free_ff;
   assign csr_ready         = 1'b1;

   // The free count can never exceed the number of blocks the map can hold.
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= FC_W'(MAX_BLOCKS - 1))
      else $error("free count beyond map size");

   // An accepted request always starts work, so no second transfer follows at once.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != ST_IDLE))
      else $error("request accepted without starting work");

   // A full-disk answer never carries a block number.
   a_full_no_grant: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == fbba_pkg::ST_FULL) |-> (rsp_granted_block == '0))
      else $error("full status with a granted block");

   // The map is only written while a request or the reset sweep is in progress.
   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff != ST_IDLE && state_ff != ST_RESP))
      else $error("map written while idle");

   // A successful grant decrements the free count by exactly one.
   a_grant_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACHK && ffs_found) |=> (free_ff == $past(free_ff) - 1'b1))
      else $error("free count not decremented on grant");

endmodule

`default_nettype wire

FILE: dv/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [fbba_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
   localparam int unsigned STALL_LIMIT = 4000;
   localparam int unsigned DRAIN_CYCLES = 40;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned PHASE_ITEMS = 200;
   localparam int unsigned PHASES = 8;

   typedef struct packed {
      logic [fbba_pkg::INDEX_W-1:0]  granted;
      logic [fbba_pkg::STATUS_W-1:0] status;
      logic [fbba_pkg::COUNT_W-1:0]  free_blocks;
   } alloc_result_type;

   class allocator_scoreboard;
      bit [fbba_pkg::MAX_BLOCKS_DEF-1:0] free_map;
      int unsigned                       free_count;
      logic [fbba_pkg::TOTAL_W-1:0]      total_blocks;
      alloc_result_type                  pending_results[$];
      int unsigned                       errors;

      function new();
         free_map = '0;
         free_count = 0;
         total_blocks = fbba_pkg::TOTAL_RESET;
         errors = 0;
      endfunction

      function int unsigned limit();
         return (total_blocks > fbba_pkg::MAX_BLOCKS_DEF) ? fbba_pkg::MAX_BLOCKS_DEF
                                                          : int'(total_blocks);
      endfunction

      function void predict_request(logic [fbba_pkg::REQ_W-1:0] kind,
                                    logic [fbba_pkg::INDEX_W-1:0] idx);
         alloc_result_type r;
         int unsigned      lim;
         int unsigned      b;
         lim = limit();
         r.granted = '0;
         r.status = fbba_pkg::ST_OK;
         case (kind)
            fbba_pkg::REQ_ALLOC: begin
               r.status = fbba_pkg::ST_FULL;
               for (b = 1; b < lim; b++) begin
                  if (free_map[b]) begin
                     free_map[b] = 1'b0;
                     free_count--;
                     r.granted = b[fbba_pkg::INDEX_W-1:0];
                     r.status = fbba_pkg::ST_OK;
                     break;
                  end
               end
            end
            fbba_pkg::REQ_RELEASE: begin
               if (idx == 0 || idx >= lim) begin
                  r.status = fbba_pkg::ST_RANGE;
               end else if (!free_map[idx]) begin
                  free_map[idx] = 1'b1;
                  free_count++;
               end
            end
            fbba_pkg::REQ_FORMAT: begin
               free_map = '0;
               free_count = 0;
               for (b = 1; b < lim; b++) begin
                  free_map[b] = 1'b1;
                  free_count++;
               end
            end
            default: begin
            end
         endcase
         r.free_blocks = (free_count > fbba_pkg::COUNT_SAT) ? fbba_pkg::COUNT_SAT
                                                            : free_count[fbba_pkg::COUNT_W-1:0];
         pending_results.push_back(r);
      endfunction

      task report(string what, int unsigned got, int unsigned wanted);
         $display("Mismatch on %s: got %0d, expected %0d", what, got, wanted);
         errors++;
      endtask

      task check_result(alloc_result_type got);
         alloc_result_type wanted;
         if (pending_results.size() == 0) begin
            report("unexpected result transfer", 32'(got), 0);
         end else begin
            wanted = pending_results.pop_front();
            if (got.granted !== wanted.granted)
               report("granted block", 32'(got.granted), 32'(wanted.granted));
            if (got.status !== wanted.status)
               report("status", 32'(got.status), 32'(wanted.status));
            if (got.free_blocks !== wanted.free_blocks)
               report("free block count", 32'(got.free_blocks), 32'(wanted.free_blocks));
         end
      endtask
   endclass

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [fbba_pkg::REQ_W-1:0]    req_type;
   logic [fbba_pkg::INDEX_W-1:0]  req_block_index;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [fbba_pkg::INDEX_W-1:0]  rsp_granted_block;
   logic [fbba_pkg::STATUS_W-1:0] rsp_status;
   logic [fbba_pkg::COUNT_W-1:0]  rsp_free_blocks;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [fbba_pkg::TOTAL_W-1:0]  csr_total_blocks;

   allocator_scoreboard sb;
   bit                  sender_idles;
   bit                  hold_request;

   free_block_bitmap_allocator dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_block_index   (req_block_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_granted_block (rsp_granted_block),
      .rsp_status        (rsp_status),
      .rsp_free_blocks   (rsp_free_blocks),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_total_blocks  (csr_total_blocks)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task send_request(input logic [fbba_pkg::REQ_W-1:0] kind,
                     input logic [fbba_pkg::INDEX_W-1:0] idx);
      int unsigned gap;
      gap = sender_idles ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_block_index <= idx;
      do @(posedge clock); while (!(req_valid && !req_stall));
      sb.predict_request(kind, idx);
   endtask

   task drain_results();
      req_valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
   endtask

   task write_total(input logic [fbba_pkg::TOTAL_W-1:0] value);
      csr_valid <= 1'b1;
      csr_total_blocks <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      sb.total_blocks = value;
   endtask

   task random_request();
      int unsigned                  pick;
      int unsigned                  lim;
      logic [fbba_pkg::INDEX_W-1:0] idx;
      pick = $urandom_range(0, 99);
      lim = sb.limit();
      idx = 10'($urandom_range(0, 1023));
      if (pick < 48) begin
         send_request(fbba_pkg::REQ_ALLOC, idx);
      end else if (pick < 92) begin
         if (lim > 1 && $urandom_range(0, 9) < 7)
            idx = 10'($urandom_range(1, lim - 1));
         send_request(fbba_pkg::REQ_RELEASE, idx);
      end else if (pick < 97) begin
         send_request(fbba_pkg::REQ_FORMAT, idx);
      end else begin
         send_request(REQ_UNUSED, idx);
      end
   endtask

   initial begin
      alloc_result_type got;
      int unsigned      gap;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         gap = $urandom_range(0, 10);
         if (hold_request) begin
            hold_request = 1'b0;
            gap = HOLD_CYCLES;
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         got.granted = rsp_granted_block;
         got.status = rsp_status;
         got.free_blocks = rsp_free_blocks;
         sb.check_result(got);
      end
   end

   initial begin
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      logic [fbba_pkg::TOTAL_W-1:0] total;
      sb = new();
      sender_idles = 1'b1;
      hold_request = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_type <= fbba_pkg::REQ_ALLOC;
      req_block_index <= '0;
      csr_valid <= 1'b0;
      csr_total_blocks <= fbba_pkg::TOTAL_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // The map starts all used, so the first allocate finds a full disk.
      send_request(fbba_pkg::REQ_ALLOC, 10'd0);
      send_request(fbba_pkg::REQ_RELEASE, 10'd0);
      send_request(fbba_pkg::REQ_RELEASE, 10'd1023);
      send_request(fbba_pkg::REQ_ALLOC, 10'h3FF);
      send_request(REQ_UNUSED, 10'h3FF);
      send_request(fbba_pkg::REQ_FORMAT, 10'd0);
      send_request(fbba_pkg::REQ_ALLOC, 10'd0);
      send_request(fbba_pkg::REQ_ALLOC, 10'd0);
      send_request(fbba_pkg::REQ_RELEASE, 10'd1);
      send_request(fbba_pkg::REQ_RELEASE, 10'd1);
      send_request(fbba_pkg::REQ_ALLOC, 10'd0);
      drain_results();

      write_total(fbba_pkg::TOTAL_CAP);
      send_request(fbba_pkg::REQ_RELEASE, 10'd1023);
      send_request(fbba_pkg::REQ_ALLOC, 10'd0);
      drain_results();

      // Shrinking the disk after a format leaves the upper free bits counted.
      write_total(11'd40);
      send_request(fbba_pkg::REQ_ALLOC, 10'd0);
      send_request(fbba_pkg::REQ_RELEASE, 10'd40);
      send_request(fbba_pkg::REQ_RELEASE, 10'd39);
      drain_results();

      write_total(11'd2);
      send_request(fbba_pkg::REQ_FORMAT, 10'd0);
      send_request(fbba_pkg::REQ_ALLOC, 10'd0);
      send_request(fbba_pkg::REQ_ALLOC, 10'd0);
      send_request(fbba_pkg::REQ_RELEASE, 10'd2);
      drain_results();

      write_total(11'd0);
      send_request(fbba_pkg::REQ_FORMAT, 10'd0);
      send_request(fbba_pkg::REQ_ALLOC, 10'd0);
      drain_results();

      write_total(11'd1);
      send_request(fbba_pkg::REQ_FORMAT, 10'd0);
      send_request(fbba_pkg::REQ_RELEASE, 10'd1);
      drain_results();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: total = fbba_pkg::TOTAL_CAP;
            1: total = 11'd2;
            2: total = 11'd33;
            3: total = 11'($urandom_range(0, 2047));
            4: total = 11'd64;
            5: total = fbba_pkg::TOTAL_RESET;
            6: total = 11'd3;
            default: total = 11'($urandom_range(2, 200));
         endcase
         write_total(total);
         sender_idles = (p != 2 && p != 6);
         if (p == 2)
            hold_request = 1'b1;
         if (p != 4)
            send_request(fbba_pkg::REQ_FORMAT, 10'($urandom_range(0, 1023)));
         for (int i = 0; i < PHASE_ITEMS; i++)
            random_request();
         drain_results();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule

FILE: files.f
sv/fbba_pkg.sv
sv/fbba_map_ram.sv
sv/fbba_ffs.sv
sv/free_block_bitmap_allocator.sv
dv/testbench.sv
